// ===== rtl/drs_pkg.sv =====
// ----------------------------------------------------------------------------
// drs_pkg
// shared codes, widths and the segment program of the disk request scheduler
// ----------------------------------------------------------------------------
package drs_pkg;

    localparam int SUM_W     = 22;
    localparam int CFG_IDX_W = 3;
    localparam int POLICY_W  = 3;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // policy codes
    localparam logic [POLICY_W-1:0] POL_FCFS  = 3'd0;
    localparam logic [POLICY_W-1:0] POL_SSTF  = 3'd1;
    localparam logic [POLICY_W-1:0] POL_SCAN  = 3'd2;
    localparam logic [POLICY_W-1:0] POL_CSCAN = 3'd3;
    localparam logic [POLICY_W-1:0] POL_LOOK  = 3'd4;
    localparam logic [POLICY_W-1:0] POL_CLOOK = 3'd5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_START  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_HIGH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT       = 3'd4;

    // register reset values
    localparam int RST_HEAD_START = 53;
    localparam int RST_TRACK_LOW  = 0;
    localparam int RST_TRACK_HIGH = 199;
    localparam int RST_SPLIT      = 99;

    // one step of a service order
    //   eq: requests on the start track, first: arrival order, sstf: nearest,
    //   bd/ba: below start descending/ascending, aa/ad: above start asc/desc,
    //   low/high: sweep end tracks
    typedef enum logic [3:0] {
        SG_EQ, SG_FIRST, SG_SSTF, SG_BD, SG_BA, SG_AA, SG_AD, SG_LOW, SG_HIGH, SG_DONE
    } t_seg;

    localparam int SEG_IDX_W = 3;

    function automatic t_seg seg_of(input logic [POLICY_W-1:0] pol, input logic down,
                                    input logic go, input logic [SEG_IDX_W-1:0] idx);
        t_seg s;
        s = SG_DONE;
        if (pol == POL_SSTF) begin
            s = SG_SSTF;
        end else if (pol == POL_SCAN || pol == POL_CSCAN || pol == POL_LOOK ||
                     pol == POL_CLOOK) begin
            unique case (idx)
                3'd0: s = SG_EQ;
                3'd1: s = down ? SG_BD : SG_AA;
                3'd2: begin
                    if (pol == POL_SCAN)       s = down ? SG_LOW : SG_HIGH;
                    else if (pol == POL_CSCAN) s = go ? (down ? SG_LOW : SG_HIGH) : SG_DONE;
                    else if (pol == POL_LOOK)  s = down ? SG_AA : SG_BD;
                    else                       s = down ? SG_AD : SG_BA;
                end
                3'd3: begin
                    if (pol == POL_SCAN)       s = down ? SG_AA : SG_BD;
                    else if (pol == POL_CSCAN) s = down ? SG_HIGH : SG_LOW;
                    else                       s = SG_DONE;
                end
                3'd4: s = (pol == POL_CSCAN) ? (down ? SG_AD : SG_BA) : SG_DONE;
                default: s = SG_DONE;
            endcase
        end else begin
            s = SG_FIRST;
        end
        return s;
    endfunction

endpackage

// ===== rtl/disk_request_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// disk_request_scheduler_core
// loads a set of track requests and delivers the service order with seek sums
// ----------------------------------------------------------------------------
// Requests are taken one word a cycle, clamped into the track range and queued
// to the engine; a word with last_request set closes the set and starts the
// schedule. The engine runs a counting pass over the stored set, then finds each
// visited request by a pass over the stored set through the single read port
// of the request store, which holds up to MAX_REQUESTS requests; an end track
// needs no pass, and each change of sweep leg adds one more pass. Intake holds
// off while a schedule runs once its two-word queue is full. Results leave
// through an output register, so the engine keeps working while a word waits.
// Configuration writes are always accepted; policy codes 6 and 7 act as FCFS.
module disk_request_scheduler_core #(
    parameter int MAX_REQUESTS = 32,
    parameter int TRACK_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [TRACK_BITS-1:0]         i_track_position,
    input  logic                          i_last_request,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [TRACK_BITS-1:0]         o_served_track,
    output logic [drs_pkg::SUM_W-1:0]     o_seek_total,
    output logic                          o_last_served,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [drs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TRACK_BITS-1:0]         i_cfg_data
);
    import drs_pkg::*;

    localparam int TB = TRACK_BITS;

    logic [POLICY_W-1:0] r_policy;
    logic [TB-1:0]       r_head_start, r_track_low, r_track_high, r_split;

    logic          q_push, q_full, q_pop, q_valid;
    logic [TB:0]   q_wdata, q_rdata;

    // configuration registers, writes beyond the list are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy     <= POL_FCFS;
            r_head_start <= TB'(RST_HEAD_START);
            r_track_low  <= TB'(RST_TRACK_LOW);
            r_track_high <= TB'(RST_TRACK_HIGH);
            r_split      <= TB'(RST_SPLIT);
        end else if (i_cfg_valid) begin
            priority case (i_cfg_index)
                CFG_POLICY:     r_policy     <= i_cfg_data[POLICY_W-1:0];
                CFG_HEAD_START: r_head_start <= i_cfg_data;
                CFG_TRACK_LOW:  r_track_low  <= i_cfg_data;
                CFG_TRACK_HIGH: r_track_high <= i_cfg_data;
                CFG_SPLIT:      r_split      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // intake: clamp and queue
    drs_front #(.TRACK_BITS(TB)) u_front (
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_track      (i_track_position),
        .i_last       (i_last_request),
        .i_track_low  (r_track_low),
        .i_track_high (r_track_high),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_data     (q_wdata)
    );

    // decoupling queue, track plus last flag
    drs_fifo #(.WIDTH(TB + 1), .DEPTH(2)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    // scheduling engine with the request store and the output register
    drs_back #(.MAX_REQUESTS(MAX_REQUESTS), .TRACK_BITS(TB)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_data     (q_rdata),
        .o_q_pop      (q_pop),
        .i_policy     (r_policy),
        .i_head_start (r_head_start),
        .i_track_low  (r_track_low),
        .i_track_high (r_track_high),
        .i_split      (r_split),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_track      (o_served_track),
        .o_sum        (o_seek_total),
        .o_last       (o_last_served)
    );

endmodule

// ===== rtl/drs_front.sv =====
// ----------------------------------------------------------------------------
// drs_front
// request intake: clamps the track into the configured range and queues it
// ----------------------------------------------------------------------------
module drs_front #(
    parameter int TRACK_BITS = 16
) (
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [TRACK_BITS-1:0] i_track,
    input  logic                  i_last,
    input  logic [TRACK_BITS-1:0] i_track_low,
    input  logic [TRACK_BITS-1:0] i_track_high,
    input  logic                  i_q_full,
    output logic                  o_q_push,
    output logic [TRACK_BITS:0]   o_q_data
);
    logic [TRACK_BITS-1:0] lo, hi, trk;

    always_comb begin
        // inverted range swaps the bounds for clamping
        lo  = (i_track_low > i_track_high) ? i_track_high : i_track_low;
        hi  = (i_track_low > i_track_high) ? i_track_low : i_track_high;
        trk = i_track;
        if (trk < lo) trk = lo;
        if (trk > hi) trk = hi;
    end

    assign o_ready  = !i_q_full;
    assign o_q_push = i_valid && !i_q_full;
    assign o_q_data = {i_last, trk};

endmodule

// ===== rtl/drs_fifo.sv =====
// ----------------------------------------------------------------------------
// drs_fifo
// short queue between request intake and the scheduling engine
// ----------------------------------------------------------------------------
module drs_fifo #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (do_pop)  r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            if (do_push && !do_pop)      r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

// ===== rtl/drs_back.sv =====
// ----------------------------------------------------------------------------
// drs_back
// scheduling engine: stores the set, then picks each visit by a scan
// ----------------------------------------------------------------------------
module drs_back #(
    parameter int MAX_REQUESTS = 32,
    parameter int TRACK_BITS   = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  logic [TRACK_BITS:0]         i_q_data,
    output logic                        o_q_pop,
    input  logic [drs_pkg::POLICY_W-1:0] i_policy,
    input  logic [TRACK_BITS-1:0]       i_head_start,
    input  logic [TRACK_BITS-1:0]       i_track_low,
    input  logic [TRACK_BITS-1:0]       i_track_high,
    input  logic [TRACK_BITS-1:0]       i_split,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [TRACK_BITS-1:0]       o_track,
    output logic [drs_pkg::SUM_W-1:0]   o_sum,
    output logic                        o_last
);
    import drs_pkg::*;

    localparam int TB = TRACK_BITS;
    localparam int IW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CW = $clog2(MAX_REQUESTS + 1);
    localparam int TW = $clog2(MAX_REQUESTS + 3);
    localparam int AW = ((TB > SUM_W) ? TB : SUM_W) + 1;

    typedef enum logic [1:0] {ST_LOAD, ST_SCAN, ST_NEXT, ST_EMIT} t_state;

    t_state              r_state;
    logic [TB-1:0]       r_mem [MAX_REQUESTS];
    logic [TB-1:0]       r_rd;
    logic [CW-1:0]       r_cnt, r_issue;
    logic [MAX_REQUESTS-1:0] r_marks;
    logic [SEG_IDX_W-1:0] r_seg;
    logic                r_counting, r_chk, r_found, r_below, r_above, r_go;
    logic [IW-1:0]       r_chk_idx, r_best_idx, r_visit_idx;
    logic [TB-1:0]       r_best_val, r_best_dist, r_visit_val, r_head;
    logic                r_visit_req;
    logic [TW-1:0]       r_total, r_emitted;
    logic [SUM_W-1:0]    r_sum;
    logic                r_out_valid, r_out_last;
    logic [TB-1:0]       r_out_track;
    logic [SUM_W-1:0]    r_out_sum;

    logic                down, take, pred, better, scan_done, out_free, mem_wr;
    t_seg                seg;
    logic [TB-1:0]       v, dist_v, vdist;
    logic [AW-1:0]       sum_ext;
    logic [SUM_W-1:0]    n_sum;
    logic [1:0]          ends;

    assign down      = (i_head_start <= i_split);
    assign seg       = seg_of(i_policy, down, r_go, r_seg);
    assign v         = r_rd;
    assign dist_v    = (v > r_head) ? v - r_head : r_head - v;
    assign scan_done = (r_issue == r_cnt) && !r_chk;
    assign out_free  = !r_out_valid || i_ready;
    assign o_q_pop   = (r_state == ST_LOAD) && i_q_valid;
    assign mem_wr    = o_q_pop && (r_cnt < CW'(MAX_REQUESTS));

    // store: one write port at load, one registered read port for the scan
    always_ff @(posedge i_clk) begin
        if (mem_wr) r_mem[r_cnt[IW-1:0]] <= i_q_data[TB-1:0];
        r_rd <= r_mem[r_issue[IW-1:0]];
    end

    // candidate test for the entry coming out of the store
    always_comb begin
        pred   = 1'b0;
        better = 1'b0;
        unique case (seg)
            SG_EQ:    begin pred = (v == i_head_start); better = !r_found; end
            SG_FIRST: begin pred = 1'b1; better = !r_found; end
            SG_SSTF:  begin pred = 1'b1; better = !r_found || (dist_v < r_best_dist); end
            SG_BD:    begin pred = (v < i_head_start); better = !r_found || (v > r_best_val); end
            SG_BA:    begin pred = (v < i_head_start); better = !r_found || (v < r_best_val); end
            SG_AA:    begin pred = (v > i_head_start); better = !r_found || (v < r_best_val); end
            SG_AD:    begin pred = (v > i_head_start); better = !r_found || (v > r_best_val); end
            default:  begin pred = 1'b0; better = 1'b0; end
        endcase
        take = r_chk && !r_counting && !r_marks[r_chk_idx] && pred && better;
    end

    // head movement of the pending visit, saturating sum
    always_comb begin
        vdist   = (r_visit_val > r_head) ? r_visit_val - r_head : r_head - r_visit_val;
        sum_ext = AW'(r_sum) + AW'(vdist);
        n_sum   = (sum_ext > AW'(SUM_MAX)) ? SUM_MAX : sum_ext[SUM_W-1:0];
    end

    // end tracks added to the request count
    always_comb begin
        if (i_policy == POL_SCAN)
            ends = 2'd1;
        else if (i_policy == POL_CSCAN)
            ends = (down ? r_above : r_below) ? 2'd2 : 2'd0;
        else
            ends = 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_cnt       <= '0;
            r_marks     <= '0;
            r_out_valid <= 1'b0;
            r_issue     <= '0;
            r_chk       <= 1'b0;
            r_counting  <= 1'b0;
            r_seg       <= '0;
            r_head      <= '0;
            r_sum       <= '0;
        end else begin
            if (r_out_valid && i_ready) r_out_valid <= 1'b0;

            // scan pipeline: issue address, check the entry in the next cycle
            if (r_state == ST_SCAN) begin
                r_chk     <= (r_issue < r_cnt);
                r_chk_idx <= r_issue[IW-1:0];
                if (r_issue < r_cnt) r_issue <= r_issue + 1'b1;
                if (r_chk && r_counting) begin
                    if (v < i_head_start) r_below <= 1'b1;
                    if (v > i_head_start) r_above <= 1'b1;
                end
                if (take) begin
                    r_found     <= 1'b1;
                    r_best_val  <= v;
                    r_best_idx  <= r_chk_idx;
                    r_best_dist <= dist_v;
                end
            end

            unique case (r_state)
                ST_LOAD: begin
                    if (i_q_valid) begin
                        if (r_cnt < CW'(MAX_REQUESTS)) r_cnt <= r_cnt + 1'b1;
                        if (i_q_data[TB]) begin
                            // counting pass first, then the service order
                            r_state    <= ST_SCAN;
                            r_counting <= 1'b1;
                            r_issue    <= '0;
                            r_chk      <= 1'b0;
                            r_below    <= 1'b0;
                            r_above    <= 1'b0;
                            r_seg      <= '0;
                            r_emitted  <= '0;
                            r_head     <= i_head_start;
                            r_sum      <= '0;
                        end
                    end
                end
                ST_SCAN: begin
                    if (scan_done) begin
                        if (r_counting) begin
                            r_counting <= 1'b0;
                            r_go       <= down ? r_above : r_below;
                            r_total    <= TW'(r_cnt) + TW'(ends);
                            r_state    <= ST_NEXT;
                        end else if (r_found) begin
                            r_visit_val <= r_best_val;
                            r_visit_idx <= r_best_idx;
                            r_visit_req <= 1'b1;
                            r_state     <= ST_EMIT;
                        end else begin
                            r_seg   <= r_seg + 1'b1;
                            r_state <= ST_NEXT;
                        end
                    end
                end
                ST_NEXT: begin
                    priority case (seg)
                        SG_LOW: begin
                            r_visit_val <= i_track_low;
                            r_visit_req <= 1'b0;
                            r_state     <= ST_EMIT;
                        end
                        SG_HIGH: begin
                            r_visit_val <= i_track_high;
                            r_visit_req <= 1'b0;
                            r_state     <= ST_EMIT;
                        end
                        SG_DONE: begin
                            r_cnt   <= '0;
                            r_marks <= '0;
                            r_state <= ST_LOAD;
                        end
                        default: begin
                            r_issue <= '0;
                            r_chk   <= 1'b0;
                            r_found <= 1'b0;
                            r_state <= ST_SCAN;
                        end
                    endcase
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_track <= r_visit_val;
                        r_out_sum   <= n_sum;
                        r_out_last  <= (r_emitted == r_total - 1'b1);
                        r_head      <= r_visit_val;
                        r_sum       <= n_sum;
                        r_emitted   <= r_emitted + 1'b1;
                        if (r_emitted == r_total - 1'b1) begin
                            r_cnt   <= '0;
                            r_marks <= '0;
                            r_state <= ST_LOAD;
                        end else begin
                            if (r_visit_req) r_marks[r_visit_idx] <= 1'b1;
                            else             r_seg <= r_seg + 1'b1;
                            r_state <= ST_NEXT;
                        end
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_track = r_out_track;
    assign o_sum   = r_out_sum;
    assign o_last  = r_out_last;

endmodule

// ===== rtl/drs_checker.sv =====
// ----------------------------------------------------------------------------
// drs_checker
// port-level checks on the result channel of the scheduler
// ----------------------------------------------------------------------------
module drs_checker #(
    parameter int TRACK_BITS = 16
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input logic [TRACK_BITS-1:0]     o_served_track,
    input logic [drs_pkg::SUM_W-1:0] o_seek_total,
    input logic                      o_last_served
);
    import drs_pkg::*;

    localparam int XW = TRACK_BITS + SUM_W + 1;

    logic                  r_in_sched;
    logic [SUM_W-1:0]      r_prev_sum;
    logic [TRACK_BITS-1:0] r_prev_track;
    logic                  acc;
    logic [TRACK_BITS-1:0] step;

    assign acc  = o_out_valid && i_out_ready;
    assign step = (o_served_track > r_prev_track) ? o_served_track - r_prev_track
                                                  : r_prev_track - o_served_track;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_sched <= 1'b0;
        end else if (acc) begin
            r_in_sched   <= !o_last_served;
            r_prev_sum   <= o_seek_total;
            r_prev_track <= o_served_track;
        end
    end

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped while stalled");

    a_word_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_served_track) && $stable(o_seek_total) && $stable(o_last_served))
        else $error("result word changed while stalled");

    a_sum_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && r_in_sched |-> o_seek_total >= r_prev_sum)
        else $error("seek total went down within a schedule");

    a_sum_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && r_in_sched && o_seek_total != SUM_MAX |->
            XW'(o_seek_total) == XW'(r_prev_sum) + XW'(step))
        else $error("seek total does not match head movement");

endmodule

bind disk_request_scheduler_core drs_checker #(.TRACK_BITS(TRACK_BITS)) u_drs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_served_track (o_served_track),
    .o_seek_total   (o_seek_total),
    .o_last_served  (o_last_served)
);

// ===== test/disk_request_scheduler_core_test.sv =====
// ----------------------------------------------------------------------------
// disk_request_scheduler_core_test
// loads request sets under every policy code and fixed and random range settings and checks each
// visit word (track, running seek sum, last flag) against an in-bench schedule
// ----------------------------------------------------------------------------
module disk_request_scheduler_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import drs_pkg::*;

    localparam int NREQ      = 32;
    localparam int TB        = 16;
    localparam int LIMIT     = 2000000;
    localparam int DRAIN_CYC = 80;

    // codes with no policy of their own, they schedule in arrival order
    localparam logic [POLICY_W-1:0] POL_SPARE_A = 3'd6;
    localparam logic [POLICY_W-1:0] POL_SPARE_B = 3'd7;
    // index beyond the register list, the write is dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd5;

    typedef struct packed {
        logic [TB-1:0]    trk;
        logic [SUM_W-1:0] sum;
        logic             fin;
    } t_visit;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [TB-1:0]     i_track_position = '0;
    logic              i_last_request = 1'b0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [TB-1:0]     o_served_track;
    logic [SUM_W-1:0]  o_seek_total;
    logic              o_last_served;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [TB-1:0]     i_cfg_data = '0;

    disk_request_scheduler_core i_dut (.*);

    always #5 i_clk = ~i_clk;

    // shadow registers and request set
    logic [POLICY_W-1:0] m_policy = POL_FCFS;
    logic [TB-1:0] m_start = TB'(RST_HEAD_START);
    logic [TB-1:0] m_low   = TB'(RST_TRACK_LOW);
    logic [TB-1:0] m_high  = TB'(RST_TRACK_HIGH);
    logic [TB-1:0] m_split = TB'(RST_SPLIT);
    logic [TB-1:0] req_set [NREQ];
    int            req_cnt = 0;

    t_visit        due_visits [$];
    logic [TB-1:0] cur_head;
    logic [SUM_W-1:0] cur_sum;

    int  fail_count = 0;
    int  sets_done = 0;
    int  words_sent = 0;
    int  words_seen = 0;
    int  cycles = 0;
    bit  quiet = 1'b0;

    // one head move of the schedule
    function automatic void visit_track(input logic [TB-1:0] trk);
        logic [TB:0] d;
        logic [SUM_W:0] s;
        t_visit v;
        d = (trk > cur_head) ? (TB+1)'(trk - cur_head) : (TB+1)'(cur_head - trk);
        s = (SUM_W+1)'(cur_sum) + (SUM_W+1)'(d);
        cur_sum = (s > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : s[SUM_W-1:0];
        cur_head = trk;
        v.trk = trk;
        v.sum = cur_sum;
        v.fin = 1'b0;
        due_visits.push_back(v);
    endfunction

    // full service order of the loaded set
    function automatic void plan_service();
        logic [TB-1:0] srt [NREQ];
        logic [TB-1:0] t;
        logic [TB:0] d, bd;
        bit done_mark [NREQ];
        int n, i, j, b, e, best, first;
        bit down;
        n = req_cnt;
        first = due_visits.size();
        down = (m_start <= m_split);
        cur_head = m_start;
        cur_sum = '0;
        for (i = 0; i < NREQ; i++) done_mark[i] = 1'b0;
        if (m_policy == POL_SSTF) begin
            for (i = 0; i < n; i++) begin
                best = -1;
                bd = '0;
                for (j = 0; j < n; j++) begin
                    if (!done_mark[j]) begin
                        d = (req_set[j] > cur_head) ? (TB+1)'(req_set[j] - cur_head)
                                                    : (TB+1)'(cur_head - req_set[j]);
                        if (best < 0 || d < bd) begin
                            best = j;
                            bd = d;
                        end
                    end
                end
                done_mark[best] = 1'b1;
                visit_track(req_set[best]);
            end
        end else if (m_policy >= POL_SCAN && m_policy <= POL_CLOOK) begin
            // insertion sort, ascending
            for (i = 0; i < n; i++) begin
                t = req_set[i];
                j = i;
                while (j > 0 && srt[j-1] > t) begin
                    srt[j] = srt[j-1];
                    j--;
                end
                srt[j] = t;
            end
            b = 0;
            while (b < n && srt[b] < m_start) b++;
            e = b;
            while (e < n && srt[e] == m_start) e++;
            for (i = b; i < e; i++) visit_track(srt[i]);
            if (down) begin
                for (i = b - 1; i >= 0; i--) visit_track(srt[i]);
                case (m_policy)
                    POL_SCAN: begin
                        visit_track(m_low);
                        for (i = e; i < n; i++) visit_track(srt[i]);
                    end
                    POL_CSCAN: begin
                        if (e < n) begin
                            visit_track(m_low);
                            visit_track(m_high);
                            for (i = n - 1; i >= e; i--) visit_track(srt[i]);
                        end
                    end
                    POL_LOOK: for (i = e; i < n; i++) visit_track(srt[i]);
                    default:  for (i = n - 1; i >= e; i--) visit_track(srt[i]);
                endcase
            end else begin
                for (i = e; i < n; i++) visit_track(srt[i]);
                case (m_policy)
                    POL_SCAN: begin
                        visit_track(m_high);
                        for (i = b - 1; i >= 0; i--) visit_track(srt[i]);
                    end
                    POL_CSCAN: begin
                        if (b > 0) begin
                            visit_track(m_high);
                            visit_track(m_low);
                            for (i = 0; i < b; i++) visit_track(srt[i]);
                        end
                    end
                    POL_LOOK: for (i = b - 1; i >= 0; i--) visit_track(srt[i]);
                    default:  for (i = 0; i < b; i++) visit_track(srt[i]);
                endcase
            end
        end else begin
            for (i = 0; i < n; i++) visit_track(req_set[i]);
        end
        if (due_visits.size() > first) due_visits[due_visits.size()-1].fin = 1'b1;
        req_cnt = 0;
        sets_done++;
    endfunction

    // clamp, store and, on the closing word, schedule
    function automatic void take_request(input logic [TB-1:0] trk, input logic fin);
        logic [TB-1:0] lo, hi, c;
        lo = (m_low > m_high) ? m_high : m_low;
        hi = (m_low > m_high) ? m_low : m_high;
        c = trk;
        if (c < lo) c = lo;
        if (c > hi) c = hi;
        if (req_cnt < NREQ) begin
            req_set[req_cnt] = c;
            req_cnt++;
        end
        if (fin) plan_service();
    endfunction

    // send one request word, sometimes with a random gap ahead of it
    task automatic send_request(input logic [TB-1:0] trk, input logic fin);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_track_position <= trk;
        i_last_request <= fin;
        do @(posedge i_clk); while (!o_in_ready);
        take_request(trk, fin);
        words_sent++;
    endtask

    // drop valid, wait for every visit, then let the engine settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (due_visits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TB-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_POLICY:     m_policy = val[POLICY_W-1:0];
            CFG_HEAD_START: m_start = val;
            CFG_TRACK_LOW:  m_low = val;
            CFG_TRACK_HIGH: m_high = val;
            CFG_SPLIT:      m_split = val;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_range(input logic [TB-1:0] st, input logic [TB-1:0] lo,
                             input logic [TB-1:0] hi, input logic [TB-1:0] sp);
        write_reg(CFG_HEAD_START, st);
        write_reg(CFG_TRACK_LOW, lo);
        write_reg(CFG_TRACK_HIGH, hi);
        write_reg(CFG_SPLIT, sp);
    endtask

    // reset register values, arrival order
    task automatic test_reset_values();
        send_request(16'd98, 1'b0);
        send_request(16'd183, 1'b0);
        send_request(16'd53, 1'b1);
        wait_idle();
    endtask

    // every policy code once, direction alternating; each set holds a request
    // on the start track, one clamped below and one clamped above
    task automatic test_policies();
        logic [POLICY_W-1:0] pols [8];
        int p;
        pols = '{POL_FCFS, POL_SSTF, POL_SCAN, POL_CSCAN, POL_LOOK, POL_CLOOK,
                 POL_SPARE_A, POL_SPARE_B};
        for (p = 0; p < 8; p++) begin
            write_reg(CFG_POLICY, TB'(pols[p]));
            set_range(16'd100, 16'd10, 16'd300, p[0] ? 16'd50 : 16'd150);
            send_request(16'hFFFF, 1'b0);
            send_request(16'd100, 1'b0);
            send_request(16'd0, 1'b1);
            wait_idle();
        end
    endtask

    // sweep policies with requests sitting on the end tracks and an inverted range
    task automatic test_end_tracks();
        write_reg(CFG_POLICY, TB'(POL_SCAN));
        set_range(16'd40, 16'd90, 16'd20, 16'd40);
        send_request(16'd20, 1'b0);
        send_request(16'd90, 1'b1);
        wait_idle();
        write_reg(CFG_UNUSED, 16'hA5A5);
        write_reg(CFG_POLICY, TB'(POL_CSCAN));
        set_range(16'd65535, 16'd0, 16'd65535, 16'd0);
        send_request(16'd0, 1'b0);
        send_request(16'd65535, 1'b1);
        wait_idle();
    endtask

    function automatic logic [TB-1:0] pick_track();
        case ($urandom_range(0, 5))
            0: return m_start;
            1: return m_low;
            2: return m_high;
            3: return TB'($urandom());
            default: return (m_low < m_high) ? TB'($urandom_range(m_low, m_high))
                                             : TB'($urandom_range(m_high, m_low));
        endcase
    endfunction

    task automatic random_config();
        logic [TB-1:0] lo, hi, st;
        write_reg(CFG_POLICY, TB'($urandom_range(0, 7)));
        case ($urandom_range(0, 4))
            0: begin lo = '0; hi = '1; end
            1: begin lo = TB'($urandom_range(100, 65535)); hi = TB'($urandom_range(0, 99)); end
            2: begin lo = TB'($urandom()); hi = TB'($urandom()); end
            default: begin
                lo = TB'($urandom_range(0, 200));
                hi = TB'($urandom_range(300, 900));
            end
        endcase
        st = ($urandom_range(0, 3) == 0) ? TB'($urandom()) : TB'($urandom_range(0, 1000));
        set_range(st, lo, hi, ($urandom_range(0, 3) == 0) ? TB'($urandom()) : st + 16'(
                  $urandom_range(0, 2) - 1));
    endtask

    // random sets, mostly short, one overfilled set to exercise dropping
    task automatic test_random_sets();
        int n, i, big_done;
        big_done = 0;
        while (words_sent < 100) begin
            if (words_sent > 85) quiet = 1'b1;
            random_config();
            if (!big_done && words_sent > 40) begin
                n = NREQ + 2;
                big_done = 1;
            end else begin
                n = $urandom_range(1, 6);
            end
            for (i = 0; i < n; i++) send_request(pick_track(), i == n - 1);
            wait_idle();
        end
    endtask

    // result side: random stall bursts
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 17);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // compare each visit word with the oldest pending one
    always @(posedge i_clk) begin
        t_visit w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            words_seen++;
            if (due_visits.size() == 0) begin
                $display("%0t: unexpected word track=%0d sum=%0d last=%0b", $time,
                         o_served_track, o_seek_total, o_last_served);
                fail_count++;
            end else begin
                w = due_visits.pop_front();
                if (o_served_track !== w.trk) begin
                    $display("%0t: served_track expected %0d actual %0d", $time, w.trk,
                             o_served_track);
                    fail_count++;
                end
                if (o_seek_total !== w.sum) begin
                    $display("%0t: seek_total expected %0d actual %0d", $time, w.sum,
                             o_seek_total);
                    fail_count++;
                end
                if (o_last_served !== w.fin) begin
                    $display("%0t: last_served expected %0b actual %0b", $time, w.fin,
                             o_last_served);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("disk_request_scheduler_core verification failed");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_policies();
        test_end_tracks();
        test_random_sets();
        wait_idle();
        if (due_visits.size() != 0) fail_count++;
        $display("covered %0d request sets, %0d request words, %0d visit words checked",
                 sets_done, words_sent, words_seen);
        $display("all policy codes, both sweep directions, clamping and overfull sets");
        if (fail_count == 0) begin
            $display("disk_request_scheduler_core verification clean");
        end else begin
            $display("disk_request_scheduler_core verification failed");
        end
        $finish;
    end

endmodule

// ===== disk_request_scheduler_core.f =====
rtl/drs_pkg.sv
rtl/drs_front.sv
rtl/drs_fifo.sv
rtl/drs_back.sv
rtl/disk_request_scheduler_core.sv
rtl/drs_checker.sv
test/disk_request_scheduler_core_test.sv
